// ===== rtl/sll_pkg.sv =====
// Shared constants and types for the streaming LIS length block.
// No dependencies.
package sll_pkg;
    localparam int MAX_LEN = 1024;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int VAL_W   = 32;
    localparam int OUT_W   = 11;

    typedef enum logic {
        ST_IDLE,
        ST_SRCH
    } t_state;
endpackage

// ===== rtl/sll_if.sv =====
// Valid/ready channels for requests into and results out of the block.
// Depends on sll_pkg.
interface sll_in_if;
    import sll_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    start_req;
    modport source (output valid, output value, output start_req, input ready);
    modport sink   (input valid, input value, input start_req, output ready);
endinterface

interface sll_out_if;
    import sll_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] length_here;
    logic [OUT_W-1:0] best_length;
    logic             overflow;
    modport source (output valid, output length_here, output best_length,
                    output overflow, input ready);
    modport sink   (input valid, input length_here, input best_length,
                    input overflow, output ready);
endinterface

// ===== rtl/sll_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

// ===== rtl/streaming_lis_length.sv =====
// Streaming longest strictly increasing subsequence length (tail table method).
// Result registered once the request is taken and the binary search has done its tail reads,
// up to log2(MAX_LEN) reads. One request in flight; a new request is taken only in idle,
// reached when the result enters the output register, later while it is not drained.
// Reset (sync, active low) clears length, state and output valid; tail RAM is not cleared.
// Depends on sll_pkg, sll_if, sll_ram.
module streaming_lis_length (
    input  logic i_clk,
    input  logic i_rst_n,
    sll_in_if.sink    i_in,
    sll_out_if.source o_out
);
    import sll_pkg::*;

    t_state                  r_state, n_state;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [AW-1:0]           r_lo, n_lo;
    logic [AW-1:0]           r_hi, n_hi;
    logic [AW-1:0]           r_mid, n_mid;
    logic                    r_pend, n_pend;
    logic                    r_ovf, n_ovf;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic signed [VAL_W-1:0] r_tail0, n_tail0;
    logic signed [VAL_W-1:0] r_last, n_last;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_W-1:0]        r_here, n_here;
    logic [OUT_W-1:0]        r_best, n_best;
    logic                    r_out_ovf, n_out_ovf;

    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic signed [VAL_W-1:0] ram_rd_data;

    logic                    out_free;
    logic                    go_right;
    logic [AW-1:0]           c_lo, c_hi, c_mid;
    logic [LEN_W-1:0]        here_len;

    sll_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_tail_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_val),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign out_free          = !r_out_valid || o_out.ready;
    assign go_right          = r_val > ram_rd_data;
    assign c_lo              = (r_pend && go_right) ? r_mid + AW'(1) : r_lo;
    assign c_hi              = (r_pend && !go_right) ? r_mid : r_hi;
    assign c_mid             = c_lo + AW'((c_hi - c_lo) >> 1);
    assign here_len          = LEN_W'(c_lo) + LEN_W'(1);

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.length_here = r_here;
    assign o_out.best_length = r_best;
    assign o_out.overflow    = r_out_ovf;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pend      = r_pend;
        n_ovf       = r_ovf;
        n_val       = r_val;
        n_tail0     = r_tail0;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_here      = r_here;
        n_best      = r_best;
        n_out_ovf   = r_out_ovf;
        ram_wr_en   = 1'b0;
        ram_wr_addr = c_lo;
        ram_rd_en   = 1'b0;
        ram_rd_addr = c_mid;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_val   = i_in.value;
                    n_pend  = 1'b0;
                    n_ovf   = 1'b0;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_state = ST_SRCH;
                    if (i_in.start_req || r_len == '0) begin
                        n_len = LEN_W'(1);
                    end else if (i_in.value < r_tail0) begin
                        n_lo = '0;
                    end else if (i_in.value > r_last) begin
                        if (r_len < LEN_W'(MAX_LEN)) begin
                            n_lo = AW'(r_len);
                            n_hi = AW'(r_len);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_hi = AW'(r_len - LEN_W'(1));
                    end
                end
            end
            ST_SRCH: begin
                if (c_lo < c_hi) begin
                    ram_rd_en = 1'b1;
                    n_mid     = c_mid;
                    n_lo      = c_lo;
                    n_hi      = c_hi;
                    n_pend    = 1'b1;
                end else if (out_free) begin
                    n_state     = ST_IDLE;
                    n_pend      = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    if (r_ovf) begin
                        n_here = OUT_W'(LEN_W'(MAX_LEN));
                        n_best = OUT_W'(r_len);
                    end else begin
                        ram_wr_en = 1'b1;
                        n_here    = OUT_W'(here_len);
                        if (LEN_W'(c_lo) == r_len) begin
                            n_len = here_len;
                        end
                        n_best = OUT_W'(n_len);
                        if (c_lo == '0) begin
                            n_tail0 = r_val;
                        end
                        if (LEN_W'(c_lo) + LEN_W'(1) >= r_len) begin
                            n_last = r_val;
                        end
                    end
                end else begin
                    n_lo   = c_lo;
                    n_hi   = c_hi;
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_ovf     <= n_ovf;
        r_val     <= n_val;
        r_tail0   <= n_tail0;
        r_last    <= n_last;
        r_here    <= n_here;
        r_best    <= n_best;
        r_out_ovf <= n_out_ovf;
    end
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for streaming_lis_length: drives requests, predicts the
// patience-table results in SystemVerilog and compares every output field.
// Depends on sll_pkg, sll_in_if, sll_out_if and the streaming_lis_length RTL.
module testbench;
    import sll_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 20;

    typedef struct packed {
        logic [OUT_W-1:0] length_here;
        logic [OUT_W-1:0] best_length;
        logic             overflow;
    } lis_result_t;

    typedef enum int {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_RISING,
        PAT_FALLING,
        PAT_EXTREME
    } value_pattern_t;

    logic i_clk;
    logic i_rst_n;

    sll_in_if  req_if ();
    sll_out_if res_if ();

    streaming_lis_length uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    logic signed [VAL_W-1:0] tail_min [MAX_LEN];
    int                      lis_len;
    lis_result_t             expected_lengths [$];
    int                      error_count;
    int                      quiet_cycles;
    bit                      tx_gaps_on;
    bit                      rx_gaps_on;
    bit                      hold_results;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic lis_result_t predict_lis(input logic signed [VAL_W-1:0] v,
                                                input logic start);
        lis_result_t r;
        int          lo;
        int          hi;
        int          mid;
        r.overflow = 1'b0;
        if (start || lis_len == 0) begin
            tail_min[0]   = v;
            lis_len       = 1;
            r.length_here = OUT_W'(1);
        end else if (v < tail_min[0]) begin
            tail_min[0]   = v;
            r.length_here = OUT_W'(1);
        end else if (v > tail_min[lis_len-1]) begin
            if (lis_len < MAX_LEN) begin
                tail_min[lis_len] = v;
                lis_len++;
                r.length_here = OUT_W'(lis_len);
            end else begin
                r.length_here = OUT_W'(MAX_LEN);
                r.overflow    = 1'b1;
            end
        end else begin
            lo = 0;
            hi = lis_len - 1;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (v > tail_min[mid])
                    lo = mid + 1;
                else
                    hi = mid;
            end
            tail_min[lo]  = v;
            r.length_here = OUT_W'(lo + 1);
        end
        r.best_length = OUT_W'(lis_len);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic signed [VAL_W-1:0] v, input logic start);
        while (tx_gaps_on && $urandom_range(0, 99) < 20) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     = 1'b1;
        req_if.value     = v;
        req_if.start_req = start;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        expected_lengths.push_back(predict_lis(v, start));
        @(negedge i_clk);
    endtask

    // Result sink
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_if.ready = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge i_clk);
                hold_results = 1'b0;
            end else begin
                res_if.ready = !(rx_gaps_on && $urandom_range(0, 99) < 20);
            end
        end
    end

    // Result check and watchdog
    always @(posedge i_clk) begin
        lis_result_t exp_r;
        if (res_if.valid && res_if.ready) begin
            if (expected_lengths.size() == 0) begin
                $error("result with no request pending: length_here %0d best_length %0d",
                       res_if.length_here, res_if.best_length);
                error_count++;
            end else begin
                exp_r = expected_lengths.pop_front();
                if (res_if.length_here !== exp_r.length_here) begin
                    $error("length_here: expected %0d, got %0d",
                           exp_r.length_here, res_if.length_here);
                    error_count++;
                end
                if (res_if.best_length !== exp_r.best_length) begin
                    $error("best_length: expected %0d, got %0d",
                           exp_r.best_length, res_if.best_length);
                    error_count++;
                end
                if (res_if.overflow !== exp_r.overflow) begin
                    $error("overflow: expected %0d, got %0d",
                           exp_r.overflow, res_if.overflow);
                    error_count++;
                end
            end
        end
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed;
        // first request carries no start after reset
        send_request(32'sd100, 1'b0);
        send_request(32'sd200, 1'b0);
        send_request(32'sd200, 1'b0);
        send_request(32'sd50, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sd150, 1'b0);
        send_request(32'sh8000_0000, 1'b1);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(-32'sd1, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh7FFF_FFFE, 1'b0);
        send_request(32'sd5, 1'b1);
        send_request(32'sd5, 1'b0);
        send_request(32'sd4, 1'b0);
        for (int k = 0; k < 5; k++)
            send_request(32'(6 + 3 * k), 1'b0);
        send_request(32'sd10, 1'b0);
        send_request(32'sd12, 1'b0);
    endtask

    task automatic test_table_full;
        longint cur;
        cur = -64'sd2147483648;
        send_request(32'(cur), 1'b1);
        for (int k = 1; k < MAX_LEN; k++) begin
            cur += $urandom_range(1, 4000000);
            send_request(32'(cur), 1'b0);
        end
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'(cur), 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sd0, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b0);
    endtask

    task automatic test_output_stall;
        int base;
        base = int'($urandom_range(0, 1000));
        hold_results = 1'b1;
        for (int k = 0; k < 12; k++)
            send_request(32'(base + 7 * k), k == 0);
    endtask

    task automatic test_random_sequences;
        int                      sent;
        int                      seq_len;
        int                      base;
        int                      stride;
        value_pattern_t          pat;
        logic signed [VAL_W-1:0] v;
        logic                    s;
        sent = 0;
        while (sent < 500) begin
            // a long stretch in the middle runs with no gaps on either side
            tx_gaps_on = !(sent >= 150 && sent < 300);
            rx_gaps_on = tx_gaps_on;
            pat     = value_pattern_t'($urandom_range(0, 4));
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 40);
            base    = int'($urandom_range(0, 2000000)) - 1000000;
            stride  = $urandom_range(1, 100);
            for (int k = 0; k < seq_len; k++) begin
                case (pat)
                    PAT_RANDOM:  v = $urandom;
                    PAT_NARROW:  v = int'($urandom_range(0, 8)) - 4;
                    PAT_RISING:  v = base + k * stride + int'($urandom_range(0, 600)) - 300;
                    PAT_FALLING: v = base - k * stride + int'($urandom_range(0, 600)) - 300;
                    default: begin
                        case ($urandom_range(0, 5))
                            0: v = 32'sh8000_0000;
                            1: v = 32'sh8000_0001;
                            2: v = -32'sd1;
                            3: v = 32'sd0;
                            4: v = 32'sh7FFF_FFFE;
                            default: v = 32'sh7FFF_FFFF;
                        endcase
                    end
                endcase
                s = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                send_request(v, s);
                sent++;
            end
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.value     = '0;
        req_if.start_req = 1'b0;
        lis_len          = 0;
        error_count      = 0;
        quiet_cycles     = 0;
        tx_gaps_on       = 1'b1;
        rx_gaps_on       = 1'b1;
        hold_results     = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_output_stall();
        test_random_sequences();

        req_if.valid = 1'b0;
        while (expected_lengths.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== streaming_lis_length.f =====
rtl/sll_pkg.sv
rtl/sll_if.sv
rtl/sll_ram.sv
rtl/streaming_lis_length.sv
test/testbench.sv
